[sv/dfo_pkg.sv]
// ----------------------------------------------------------------------------
// dfo_pkg
// shared widths, constants and codes of the distance fade opacity block
// ----------------------------------------------------------------------------
`default_nettype none
package dfo_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int DIST_BITS      = 25;
	localparam int MAG_BITS       = DIST_BITS + 1;
	localparam int SQ_BITS        = 2 * MAG_BITS;
	localparam int ROOT_BITS      = MAG_BITS;
	localparam int REM_BITS       = ROOT_BITS + 2;
	localparam int FRAC_BITS      = 16;
	localparam int OPA_BITS       = FRAC_BITS + 1;
	localparam int OUT_TDATA_BITS = ((OPA_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_BITS   = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_TRANSP = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_OPAQUE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FAR_OPAQUE  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FAR_TRANSP  = 2'd3;

	typedef enum logic [1:0] {
		OP_ZERO,
		OP_ONE,
		OP_FAR,
		OP_NEAR
	} op_code_t;

	localparam logic [OPA_BITS-1:0] ONE_Q16 = OPA_BITS'(1) << FRAC_BITS;
	localparam logic [MAG_BITS-1:0] MAG_LIM = MAG_BITS'(1) << DIST_BITS;
endpackage
`default_nettype wire

[sv/distance_fade_opacity.sv]
// ----------------------------------------------------------------------------
// distance_fade_opacity
// euclidean distance of two points mapped to a trapezoid q1.16 opacity
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: target_x, target_y, target_z, ref_x, ref_y, ref_z
// m_axis    out  tdata: opacity
// cfg       in   cfg_we, cfg_idx, cfg_wdata (four 25-bit distances)
//
// one transaction per cycle sustained while the output is not held by m_tready;
// the square root takes one bit pair per stage, the divider one bit per stage
// all pipeline stages freeze together when the output is held by m_tready
// reset clears the valid bits and the distance registers to zero
// ----------------------------------------------------------------------------
`default_nettype none
module distance_fade_opacity #(
	parameter int COORD_BITS = dfo_pkg::COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// target_x, target_y, target_z, ref_x, ref_y, ref_z, zero fill
	input  wire logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// opacity, zero fill
	output logic [dfo_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
	input  wire logic cfg_we,
	input  wire logic [dfo_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  wire logic [dfo_pkg::DIST_BITS-1:0] cfg_wdata
);
	import dfo_pkg::*;

	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int MW = (DIFF_BITS > MAG_BITS) ? DIFF_BITS : MAG_BITS;
	localparam int SQ_N = ROOT_BITS;
	localparam int DV_N = FRAC_BITS;
	localparam int DSQ = 2 * DIST_BITS;

	logic [DIST_BITS-1:0] nt_q, no_q, fo_q, ft_q;
	logic [DSQ-1:0] nt2_q, no2_q, fo2_q, ft2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nt_q <= '0;
			no_q <= '0;
			fo_q <= '0;
			ft_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_NEAR_TRANSP: nt_q <= cfg_wdata;
				REG_NEAR_OPAQUE: no_q <= cfg_wdata;
				REG_FAR_OPAQUE:  fo_q <= cfg_wdata;
				REG_FAR_TRANSP:  ft_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		nt2_q <= DSQ'(nt_q) * DSQ'(nt_q);
		no2_q <= DSQ'(no_q) * DSQ'(no_q);
		fo2_q <= DSQ'(fo_q) * DSQ'(fo_q);
		ft2_q <= DSQ'(ft_q) * DSQ'(ft_q);
	end

	logic adv;
	logic v_out;
	assign adv = !v_out || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: saturated absolute differences
	logic [MAG_BITS-1:0] mag_n [3];
	logic [MAG_BITS-1:0] mag_s1 [3];
	logic v_s1;

	always_comb begin
		logic signed [DIFF_BITS-1:0] a, b, d;
		logic [MW-1:0] m;
		for (int k = 0; k < 3; k++) begin
			a = DIFF_BITS'($signed(s_axis_tdata[k*COORD_BITS +: COORD_BITS]));
			b = DIFF_BITS'($signed(s_axis_tdata[(k+3)*COORD_BITS +: COORD_BITS]));
			d = a - b;
			m = MW'(d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d));
			mag_n[k] = (m > MW'(MAG_LIM)) ? MAG_LIM : m[MAG_BITS-1:0];
		end
	end

	// stage 2: squares, stage 3: sum
	logic [SQ_BITS-1:0] sq_s2 [3];
	logic [SQ_BITS-1:0] sum_s3;
	logic v_s2, v_s3;

	// stage 4 / root stages
	logic [SQ_BITS-1:0]   rs_s   [SQ_N+1];
	logic [REM_BITS-1:0]  rrem_s [SQ_N+1];
	logic [ROOT_BITS-1:0] rroot_s[SQ_N+1];
	op_code_t             rcode_s[SQ_N+1];
	logic [DIST_BITS-1:0] rlo_s  [SQ_N+1];
	logic [DIST_BITS-1:0] rhi_s  [SQ_N+1];
	logic                 rv_s   [SQ_N+1];

	op_code_t code_n;
	logic [DIST_BITS-1:0] lo_n, hi_n;
	always_comb begin
		lo_n = nt_q;
		hi_n = no_q;
		if (sum_s3 > SQ_BITS'(ft2_q)) begin
			code_n = OP_ZERO;
		end else if (sum_s3 < SQ_BITS'(nt2_q)) begin
			code_n = OP_ZERO;
		end else if (sum_s3 > SQ_BITS'(fo2_q)) begin
			code_n = OP_FAR;
			lo_n = fo_q;
			hi_n = ft_q;
		end else if (sum_s3 < SQ_BITS'(no2_q)) begin
			code_n = OP_NEAR;
		end else begin
			code_n = OP_ONE;
		end
	end

	logic [REM_BITS-1:0]  rrem_n [SQ_N];
	logic [ROOT_BITS-1:0] rroot_n[SQ_N];
	always_comb begin
		logic [REM_BITS+1:0] sh, trial;
		logic ge;
		for (int j = 0; j < SQ_N; j++) begin
			sh = {rrem_s[j], rs_s[j][2*(SQ_N-1-j) +: 2]};
			trial = (REM_BITS+2)'({rroot_s[j], 2'b01});
			ge = sh >= trial;
			rrem_n[j] = ge ? REM_BITS'(sh - trial) : REM_BITS'(sh);
			rroot_n[j] = {rroot_s[j][ROOT_BITS-2:0], ge};
		end
	end

	// ramp setup
	logic [DIST_BITS-1:0] dnum_n, dwid_n;
	logic dfull_n;
	always_comb begin
		logic [ROOT_BITS-1:0] d, num;
		d = rroot_s[SQ_N];
		num = (d > ROOT_BITS'(rlo_s[SQ_N])) ? d - ROOT_BITS'(rlo_s[SQ_N]) : '0;
		dwid_n = rhi_s[SQ_N] - rlo_s[SQ_N];
		dfull_n = (rhi_s[SQ_N] <= rlo_s[SQ_N]) || (num >= ROOT_BITS'(dwid_n));
		dnum_n = num[DIST_BITS-1:0];
	end

	// divider stages
	logic [DIST_BITS-1:0] drem_s [DV_N+1];
	logic [DIST_BITS-1:0] dwid_s [DV_N+1];
	logic [FRAC_BITS-1:0] dq_s   [DV_N+1];
	logic                 dfull_s[DV_N+1];
	op_code_t             dcode_s[DV_N+1];
	logic                 dv_s   [DV_N+1];

	logic [DIST_BITS-1:0] drem_n[DV_N];
	logic [FRAC_BITS-1:0] dq_n  [DV_N];
	always_comb begin
		logic [DIST_BITS:0] r2;
		logic ge;
		for (int j = 0; j < DV_N; j++) begin
			r2 = {drem_s[j], 1'b0};
			ge = r2 >= (DIST_BITS+1)'(dwid_s[j]);
			drem_n[j] = ge ? DIST_BITS'(r2 - (DIST_BITS+1)'(dwid_s[j])) : DIST_BITS'(r2);
			dq_n[j] = {dq_s[j][FRAC_BITS-2:0], ge};
		end
	end

	logic [OPA_BITS-1:0] opa_n, opa_s;
	always_comb begin
		logic [OPA_BITS-1:0] t;
		t = dfull_s[DV_N] ? ONE_Q16 : OPA_BITS'(dq_s[DV_N]);
		case (dcode_s[DV_N])
			OP_ZERO: opa_n = '0;
			OP_ONE:  opa_n = ONE_Q16;
			OP_FAR:  opa_n = ONE_Q16 - t;
			OP_NEAR: opa_n = t;
			default: opa_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int j = 0; j <= SQ_N; j++) rv_s[j] <= 1'b0;
			for (int j = 0; j <= DV_N; j++) dv_s[j] <= 1'b0;
			v_out <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			rv_s[0] <= v_s3;
			for (int j = 0; j < SQ_N; j++) rv_s[j+1] <= rv_s[j];
			dv_s[0] <= rv_s[SQ_N];
			for (int j = 0; j < DV_N; j++) dv_s[j+1] <= dv_s[j];
			v_out <= dv_s[DV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				mag_s1[k] <= mag_n[k];
				sq_s2[k] <= SQ_BITS'(mag_s1[k]) * SQ_BITS'(mag_s1[k]);
			end
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			rs_s[0] <= sum_s3;
			rrem_s[0] <= '0;
			rroot_s[0] <= '0;
			rcode_s[0] <= code_n;
			rlo_s[0] <= lo_n;
			rhi_s[0] <= hi_n;
			for (int j = 0; j < SQ_N; j++) begin
				rs_s[j+1] <= rs_s[j];
				rrem_s[j+1] <= rrem_n[j];
				rroot_s[j+1] <= rroot_n[j];
				rcode_s[j+1] <= rcode_s[j];
				rlo_s[j+1] <= rlo_s[j];
				rhi_s[j+1] <= rhi_s[j];
			end
			drem_s[0] <= dnum_n;
			dwid_s[0] <= dwid_n;
			dq_s[0] <= '0;
			dfull_s[0] <= dfull_n;
			dcode_s[0] <= rcode_s[SQ_N];
			for (int j = 0; j < DV_N; j++) begin
				drem_s[j+1] <= drem_n[j];
				dwid_s[j+1] <= dwid_s[j];
				dq_s[j+1] <= dq_n[j];
				dfull_s[j+1] <= dfull_s[j];
				dcode_s[j+1] <= dcode_s[j];
			end
			opa_s <= opa_n;
		end
	end

	assign m_axis_tvalid = v_out;
	assign m_axis_tdata = OUT_TDATA_BITS'(opa_s);
endmodule
`default_nettype wire
